FILE: rtl/core/pcb_pkg.sv
// Package for the palette color blend block: channel and color types,
// palette geometry, request and register codes.
// No dependencies.
`default_nettype none

package pcb_pkg;

	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned NCHAN   = 3;
	localparam int unsigned DEPTH   = 16;
	localparam int unsigned IDX_W   = 4;
	localparam int unsigned FRAC_W  = 8;
	localparam int unsigned MULT_W  = 9;
	localparam int unsigned PROD_W  = CHAN_W + MULT_W;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

	typedef logic [CHAN_W-1:0] chan_t;
	// index 0 red, 1 green, 2 blue
	typedef chan_t [NCHAN-1:0] rgb_t;

	typedef enum logic {
		ACT_LOOKUP = 1'b0,
		ACT_WRITE  = 1'b1
	} action_t;

	typedef enum logic {
		REG_BLEND_ENABLE = 1'b0,
		REG_SCALE_FIXED  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] slot;
		rgb_t             data;
	} pal_wr_t;

endpackage

`default_nettype wire

FILE: rtl/core/pcb_palette.sv
// Palette store: 16 RGB entries, one write port, two registered read ports
// (entry and its wrapped neighbor). Entries read as zero until written.
// Depends on pcb_pkg.
`default_nettype none

module pcb_palette (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pcb_pkg::pal_wr_t  wr,
	input  wire logic              rd_en,
	input  wire logic [pcb_pkg::IDX_W-1:0] rd_idx,
	output pcb_pkg::rgb_t          rd_a,
	output pcb_pkg::rgb_t          rd_b
);

	pcb_pkg::rgb_t               mem_q [pcb_pkg::DEPTH];
	logic [pcb_pkg::DEPTH-1:0]   valid_q;
	logic [pcb_pkg::IDX_W-1:0]   nx_idx;
	pcb_pkg::rgb_t               rd_a_q;
	pcb_pkg::rgb_t               rd_b_q;
	logic                        va_q;
	logic                        vb_q;

	assign nx_idx = rd_idx + 1'b1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.slot] <= wr.data;
		end
		if (rd_en) begin
			rd_a_q <= mem_q[rd_idx];
			rd_b_q <= mem_q[nx_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			va_q    <= 1'b0;
			vb_q    <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.slot] <= 1'b1;
			end
			if (rd_en) begin
				va_q <= valid_q[rd_idx];
				vb_q <= valid_q[nx_idx];
			end
		end
	end

	assign rd_a = va_q ? rd_a_q : '0;
	assign rd_b = vb_q ? rd_b_q : '0;

	a_wr_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> valid_q[$past(wr.slot)])
		else $error("palette entry not marked valid after write");

	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!rd_en |=> $stable(rd_a_q) && $stable(rd_b_q) && $stable(va_q) && $stable(vb_q))
		else $error("palette read data changed while stalled");

	a_nx_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && rd_idx == '1 |=> vb_q == $past(valid_q[0]))
		else $error("neighbor of last entry is not entry zero");

endmodule

`default_nettype wire

FILE: rtl/core/palette_color_blend.sv
// Top level of the palette color blend block: stream ports, config
// registers and the five-stage lookup pipeline.
// Depends on pcb_pkg and pcb_palette.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------
//  s_axis   | s_axis_tvalid/tready     | tdata: color_index, brightness, slot,
//           |                          |   slot_red/green/blue; tuser: action
//  m_axis   | m_axis_tvalid/tready     | tdata: red_out, green_out, blue_out
//  cfg      | cfg_valid/cfg_ready      | cfg_index, cfg_data
//
// One request per cycle while m_axis is not stalled; a lookup result passes
// through palette read, two scale multiplies, blend sum, dim multiply, output.
// Palette writes take effect at accept and give no result.
// arst_n clears pipeline valids, palette valid bits and config to defaults.
// A stall on m_axis freezes every stage and drops s_axis_tready.
`default_nettype none

module palette_color_blend (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [15:0] color_index, [23:16] brightness, [27:24] slot, [35:28] slot_red,
	// [43:36] slot_green, [51:44] slot_blue, [55:52] zero
	input  wire logic [55:0] s_axis_tdata,
	// [0] action
	input  wire logic        s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [7:0] red_out, [15:8] green_out, [23:16] blue_out
	output logic [23:0]      m_axis_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic        cfg_data
);

	localparam int unsigned CW = pcb_pkg::CHAN_W;
	localparam int unsigned MW = pcb_pkg::MULT_W;
	localparam int unsigned PW = pcb_pkg::PROD_W;

	logic                          blend_enable_q;
	logic                          scale_fixed_q;
	logic                          adv;
	logic                          s_acc;
	logic                          is_lookup;
	logic [15:0]                   color_index;
	logic [pcb_pkg::FRAC_W-1:0]    frac_in;
	pcb_pkg::pal_wr_t              pal_wr;
	pcb_pkg::rgb_t                 a_s1;
	pcb_pkg::rgb_t                 b_s1;

	logic                          valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [pcb_pkg::FRAC_W-1:0]    frac_s1;
	logic                          blend_s1, blend_s2;
	pcb_pkg::chan_t                bri_s1, bri_s2, bri_s3, bri_s4;
	pcb_pkg::rgb_t                 a_s2, sa_s2, sb_s2;
	pcb_pkg::rgb_t                 c_s3, c_s4, sc_s4;
	pcb_pkg::rgb_t                 out_s5;

	logic [MW-1:0]                 ma, mb, md;
	pcb_pkg::rgb_t                 sa, sb, cb, sc, fin;
	logic [PW-1:0]                 pa [pcb_pkg::NCHAN];
	logic [PW-1:0]                 pb [pcb_pkg::NCHAN];
	logic [PW-1:0]                 pd [pcb_pkg::NCHAN];

	assign adv           = !valid_s5 || m_axis_tready;
	assign s_axis_tready = adv;
	assign s_acc         = s_axis_tvalid && adv;
	assign is_lookup     = (s_axis_tuser == pcb_pkg::ACT_LOOKUP);
	assign color_index   = s_axis_tdata[15:0];
	assign frac_in       = color_index[11:4];
	assign cfg_ready     = 1'b1;

	assign pal_wr.en   = s_acc && (s_axis_tuser == pcb_pkg::ACT_WRITE);
	assign pal_wr.slot = s_axis_tdata[27:24];
	assign pal_wr.data = s_axis_tdata[51:28];

	pcb_palette u_palette (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (pal_wr),
		.rd_en  (adv),
		.rd_idx (color_index[15:12]),
		.rd_a   (a_s1),
		.rd_b   (b_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_enable_q <= 1'b1;
			scale_fixed_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pcb_pkg::REG_BLEND_ENABLE: blend_enable_q <= cfg_data;
				pcb_pkg::REG_SCALE_FIXED:  scale_fixed_q  <= cfg_data;
				default:                   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_acc && is_lookup;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// blend weights: scale8(a, 255-f) and scale8(b, f)
	always_comb begin
		ma = scale_fixed_q ? (MW'(256) - MW'(frac_s1)) : (MW'(255) - MW'(frac_s1));
		mb = scale_fixed_q ? (MW'(frac_s1) + MW'(1)) : MW'(frac_s1);
		for (int i = 0; i < pcb_pkg::NCHAN; i++) begin
			pa[i] = PW'(a_s1[i]) * PW'(ma);
			pb[i] = PW'(b_s1[i]) * PW'(mb);
			sa[i] = pa[i][2*CW-1:CW];
			sb[i] = pb[i][2*CW-1:CW];
		end
	end

	always_comb begin
		for (int i = 0; i < pcb_pkg::NCHAN; i++) begin
			cb[i] = blend_s2 ? (sa_s2[i] + sb_s2[i]) : a_s2[i];
		end
	end

	// dim factor: scale8(c, bri+1)
	always_comb begin
		md = scale_fixed_q ? (MW'(bri_s3) + MW'(2)) : (MW'(bri_s3) + MW'(1));
		for (int i = 0; i < pcb_pkg::NCHAN; i++) begin
			pd[i] = PW'(c_s3[i]) * PW'(md);
			sc[i] = pd[i][2*CW-1:CW];
		end
	end

	always_comb begin
		for (int i = 0; i < pcb_pkg::NCHAN; i++) begin
			priority if (bri_s4 == pcb_pkg::CHAN_MAX) begin
				fin[i] = c_s4[i];
			end else if (bri_s4 == '0 || c_s4[i] == '0) begin
				fin[i] = '0;
			end else begin
				fin[i] = sc_s4[i] + CW'(!scale_fixed_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			frac_s1  <= frac_in;
			bri_s1   <= s_axis_tdata[23:16];
			blend_s1 <= blend_enable_q && (frac_in != '0);

			a_s2     <= a_s1;
			sa_s2    <= sa;
			sb_s2    <= sb;
			blend_s2 <= blend_s1;
			bri_s2   <= bri_s1;

			c_s3     <= cb;
			bri_s3   <= bri_s2;

			c_s4     <= c_s3;
			sc_s4    <= sc;
			bri_s4   <= bri_s3;

			out_s5   <= fin;
		end
	end

	assign m_axis_tvalid = valid_s5;
	assign m_axis_tdata  = out_s5;

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == pcb_pkg::ACT_WRITE |=> !valid_s1)
		else $error("palette write entered the lookup pipeline");

	a_lookup_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == pcb_pkg::ACT_LOOKUP |=> valid_s1)
		else $error("accepted lookup lost at stage one");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({valid_s1, valid_s2, valid_s3, valid_s4}) && $stable(c_s4))
		else $error("pipeline moved during stall");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s4 && bri_s4 == '0 |=> m_axis_tvalid && m_axis_tdata == '0)
		else $error("zero brightness did not give black");

endmodule

`default_nettype wire

FILE: test/tb_palette_color_blend.sv
// Testbench for palette_color_blend: drives palette writes and lookups on the
// request stream and checks every color result against a local predictor.
// Depends on pcb_pkg and the palette_color_blend RTL.
`default_nettype none

module tb_palette_color_blend;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		pcb_pkg::action_t          act;
		logic [15:0]               color_index;
		pcb_pkg::chan_t            brightness;
		logic [pcb_pkg::IDX_W-1:0] slot;
		pcb_pkg::rgb_t             color;
	} pix_req_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// [15:0] color_index, [23:16] brightness, [27:24] slot, [35:28] slot_red,
	// [43:36] slot_green, [51:44] slot_blue, [55:52] zero
	logic [55:0] s_axis_tdata;
	// [0] action
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// [7:0] red_out, [15:8] green_out, [23:16] blue_out
	logic [23:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic        cfg_data;

	pcb_pkg::rgb_t  shadow_palette [pcb_pkg::DEPTH];
	logic           blend_on;
	logic           fixed_round;
	pcb_pkg::rgb_t  expected_colors [$];
	int             fail_count;
	bit             gaps_on;
	bit             stalls_on;
	int             hold_left;

	palette_color_blend uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("palette_color_blend verification failed");
		$finish;
	end

	function automatic pcb_pkg::chan_t scale_chan(input pcb_pkg::chan_t x,
			input int unsigned s);
		int unsigned m;
		m = fixed_round ? s + 1 : s;
		return pcb_pkg::chan_t'((int'(x) * m) >> 8);
	endfunction

	function automatic pcb_pkg::chan_t dim_chan(input pcb_pkg::chan_t c,
			input int unsigned s);
		int unsigned v;
		if (c == 0)
			return '0;
		v = scale_chan(c, s);
		if (!fixed_round)
			v = v + 1;
		return pcb_pkg::chan_t'(v & 8'hFF);
	endfunction

	function automatic pcb_pkg::rgb_t lookup_color(input logic [15:0] pos,
			input pcb_pkg::chan_t bri);
		logic [pcb_pkg::IDX_W-1:0]  entry;
		logic [pcb_pkg::IDX_W-1:0]  nxt;
		logic [pcb_pkg::FRAC_W-1:0] frac;
		pcb_pkg::rgb_t              col;
		pcb_pkg::rgb_t              nb;
		entry = pos[15:12];
		frac  = pos[11:4];
		nxt   = entry + 1'b1;
		col   = shadow_palette[entry];
		nb    = shadow_palette[nxt];
		for (int c = 0; c < pcb_pkg::NCHAN; c++) begin
			if (blend_on && frac != 0)
				col[c] = pcb_pkg::chan_t'(scale_chan(col[c], 255 - frac)
					+ scale_chan(nb[c], frac));
			if (bri == 0)
				col[c] = '0;
			else if (bri != pcb_pkg::CHAN_MAX)
				col[c] = dim_chan(col[c], int'(bri) + 1);
		end
		return col;
	endfunction

	function automatic void predict_request(input pix_req_t rq);
		if (rq.act == pcb_pkg::ACT_WRITE)
			shadow_palette[rq.slot] = rq.color;
		else
			expected_colors.push_back(lookup_color(rq.color_index, rq.brightness));
	endfunction

	function automatic pcb_pkg::chan_t random_chan();
		case ($urandom_range(7))
			0: return '0;
			1: return pcb_pkg::CHAN_MAX;
			default: return pcb_pkg::chan_t'($urandom_range(255));
		endcase
	endfunction

	function automatic pix_req_t random_request(input int write_pct);
		pix_req_t rq;
		rq.act         = ($urandom_range(99) < write_pct) ? pcb_pkg::ACT_WRITE
			: pcb_pkg::ACT_LOOKUP;
		rq.color_index = 16'($urandom_range(16'hFFFF));
		if ($urandom_range(5) == 0)
			rq.color_index[11:4] = '0;
		case ($urandom_range(9))
			0: rq.brightness = pcb_pkg::CHAN_MAX;
			1: rq.brightness = '0;
			default: rq.brightness = pcb_pkg::chan_t'($urandom_range(255));
		endcase
		rq.slot = 4'($urandom_range(15));
		for (int c = 0; c < pcb_pkg::NCHAN; c++)
			rq.color[c] = random_chan();
		return rq;
	endfunction

	function automatic pix_req_t make_request(input pcb_pkg::action_t act,
			input logic [15:0] pos, input pcb_pkg::chan_t bri, input logic [3:0] slot,
			input pcb_pkg::rgb_t col);
		pix_req_t rq;
		rq.act         = act;
		rq.color_index = pos;
		rq.brightness  = bri;
		rq.slot        = slot;
		rq.color       = col;
		return rq;
	endfunction

	task automatic send_request(input pix_req_t rq);
		@(negedge clk);
		if (gaps_on && $urandom_range(99) < 13) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= rq.act;
		s_axis_tdata  <= {4'b0, rq.color[2], rq.color[1], rq.color[0], rq.slot,
			rq.brightness, rq.color_index};
		do @(posedge clk); while (!s_axis_tready);
		predict_request(rq);
	endtask

	task automatic drop_request();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic drain_results();
		drop_request();
		while (expected_colors.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input pcb_pkg::reg_idx_t idx, input logic val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == pcb_pkg::REG_BLEND_ENABLE)
			blend_on = val;
		else
			fixed_round = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_mode(input logic blend, input logic fixed);
		drain_results();
		write_reg(pcb_pkg::REG_BLEND_ENABLE, blend);
		write_reg(pcb_pkg::REG_SCALE_FIXED, fixed);
	endtask

	task automatic run_directed_checks();
		pcb_pkg::rgb_t white;
		pcb_pkg::rgb_t mix;
		white = {pcb_pkg::CHAN_MAX, pcb_pkg::CHAN_MAX, pcb_pkg::CHAN_MAX};
		mix   = {8'h10, 8'h80, 8'hF0};
		// lookup of untouched palette gives black
		send_request(make_request(pcb_pkg::ACT_LOOKUP, 16'h5A5F, pcb_pkg::CHAN_MAX, 4'hF,
			white));
		send_request(make_request(pcb_pkg::ACT_WRITE, 16'hFFFF, pcb_pkg::CHAN_MAX, 4'h0,
			white));
		send_request(make_request(pcb_pkg::ACT_WRITE, 16'hFFFF, 8'h00, 4'hF, mix));
		send_request(make_request(pcb_pkg::ACT_WRITE, 16'h0000, 8'h00, 4'h1,
			{8'h01, 8'hFE, 8'h7F}));
		send_request(make_request(pcb_pkg::ACT_LOOKUP, 16'h0000, pcb_pkg::CHAN_MAX, 4'h3,
			white));
		send_request(make_request(pcb_pkg::ACT_LOOKUP, 16'hF000, pcb_pkg::CHAN_MAX, 4'h3,
			white));
		send_request(make_request(pcb_pkg::ACT_LOOKUP, 16'h000F, pcb_pkg::CHAN_MAX, 4'h0,
			white));
		// entry 15 blends toward entry 0
		send_request(make_request(pcb_pkg::ACT_LOOKUP, 16'hF800, pcb_pkg::CHAN_MAX, 4'h0,
			'0));
		send_request(make_request(pcb_pkg::ACT_LOOKUP, 16'hFFF0, pcb_pkg::CHAN_MAX, 4'h0,
			'0));
		send_request(make_request(pcb_pkg::ACT_LOOKUP, 16'h0010, pcb_pkg::CHAN_MAX, 4'h0,
			'0));
		send_request(make_request(pcb_pkg::ACT_LOOKUP, 16'h0FF0, pcb_pkg::CHAN_MAX, 4'h0,
			'0));
		send_request(make_request(pcb_pkg::ACT_LOOKUP, 16'h0800, pcb_pkg::CHAN_MAX, 4'h0,
			'0));
		// brightness extremes
		send_request(make_request(pcb_pkg::ACT_LOOKUP, 16'h0000, 8'h00, 4'h0, '0));
		send_request(make_request(pcb_pkg::ACT_LOOKUP, 16'h0000, 8'h01, 4'h0, '0));
		send_request(make_request(pcb_pkg::ACT_LOOKUP, 16'h0000, 8'hFE, 4'h0, '0));
		send_request(make_request(pcb_pkg::ACT_LOOKUP, 16'hF7F0, 8'h80, 4'h0, '0));
		send_request(make_request(pcb_pkg::ACT_LOOKUP, 16'h1000, 8'h40, 4'hF, white));
		send_request(make_request(pcb_pkg::ACT_LOOKUP, 16'h1FFF, 8'h00, 4'hF, white));
		// write right before a lookup of the same entry
		send_request(make_request(pcb_pkg::ACT_WRITE, 16'h0000, 8'h00, 4'h2, mix));
		send_request(make_request(pcb_pkg::ACT_LOOKUP, 16'h2000, pcb_pkg::CHAN_MAX, 4'h0,
			'0));
		send_request(make_request(pcb_pkg::ACT_LOOKUP, 16'h1800, 8'hC0, 4'h0, '0));
		drain_results();
	endtask

	task automatic run_random_phase(input logic blend, input logic fixed, input int count);
		set_mode(blend, fixed);
		for (int i = 0; i < count; i++)
			send_request(random_request(30));
	endtask

	task automatic run_config_sweep();
		run_random_phase(1'b0, 1'b1, 350);
		run_random_phase(1'b1, 1'b0, 350);
		run_random_phase(1'b0, 1'b0, 300);
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		run_random_phase(1'b1, 1'b1, 200);
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		run_random_phase(1'b1, 1'b1, 200);
	endtask

	task automatic run_stall_fill();
		drain_results();
		hold_left = 120;
		for (int i = 0; i < 60; i++)
			send_request(random_request(10));
		drain_results();
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			m_axis_tready <= !(stalls_on && $urandom_range(99) < 13);
		end
	end

	always @(posedge clk) begin
		pcb_pkg::rgb_t want;
		pcb_pkg::rgb_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (expected_colors.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, m_axis_tdata);
				fail_count++;
			end else begin
				want = expected_colors.pop_front();
				if (got[0] != want[0]) begin
					$display("%0t: red_out expected %h actual %h", $realtime, want[0], got[0]);
					fail_count++;
				end
				if (got[1] != want[1]) begin
					$display("%0t: green_out expected %h actual %h", $realtime, want[1], got[1]);
					fail_count++;
				end
				if (got[2] != want[2]) begin
					$display("%0t: blue_out expected %h actual %h", $realtime, want[2], got[2]);
					fail_count++;
				end
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = 1'b0;
		cfg_data      = 1'b0;
		blend_on      = 1'b1;
		fixed_round   = 1'b1;
		fail_count    = 0;
		gaps_on       = 1'b1;
		stalls_on     = 1'b1;
		hold_left     = 0;
		for (int i = 0; i < pcb_pkg::DEPTH; i++)
			shadow_palette[i] = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		run_directed_checks();
		run_config_sweep();
		run_stall_fill();
		run_random_phase(1'b1, 1'b1, 100);
		drain_results();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("palette_color_blend verification clean");
		else
			$display("palette_color_blend verification failed");
		$finish;
	end

endmodule

`default_nettype wire
